@@ rtl/core/mahd_pkg.sv @@
`default_nettype none

package mahd_pkg;

   // classified-item queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // frame length datapath
   localparam int NUM_W      = 20;
   localparam int MUL_W      = 25;
   localparam int PROD_W     = NUM_W + MUL_W;
   localparam int PROD_SHIFT = 29;
   localparam int QUO_W      = PROD_W - PROD_SHIFT;
   localparam int LEN_W      = QUO_W + 2;

   localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(2880);

   // header codes
   localparam logic [1:0] VCODE_MPEG1    = 2'b11;
   localparam logic [1:0] VCODE_MPEG2    = 2'b10;
   localparam logic [1:0] VCODE_RESERVED = 2'b01;
   localparam logic [1:0] LCODE_RESERVED = 2'b00;
   localparam logic [1:0] LCODE_LAYER2   = 2'b10;
   localparam logic [1:0] LCODE_LAYER1   = 2'b11;
   localparam logic [3:0] BR_FREE        = 4'd0;
   localparam logic [3:0] BR_BAD         = 4'd15;
   localparam logic [1:0] SR_FAMILY_44K  = 2'd0;
   localparam logic [1:0] SR_RESERVED    = 2'd3;
   localparam logic [1:0] EMPH_RESERVED  = 2'b10;
   localparam logic [1:0] MODE_MONO      = 2'b11;

   // decoded version codes
   localparam logic [1:0] VER_MPEG1  = 2'd0;
   localparam logic [1:0] VER_MPEG2  = 2'd1;
   localparam logic [1:0] VER_MPEG25 = 2'd2;

   localparam logic [1:0] LAYER_1 = 2'd1;

   localparam logic [10:0] SPF_LAYER1 = 11'd384;
   localparam logic [10:0] SPF_LONG   = 11'd1152;
   localparam logic [10:0] SPF_SHORT  = 11'd576;

   localparam logic [5:0] OFFS_M1_STEREO = 6'd36;
   localparam logic [5:0] OFFS_M1_MONO   = 6'd21;
   localparam logic [5:0] OFFS_M2_STEREO = 6'd21;
   localparam logic [5:0] OFFS_M2_MONO   = 6'd13;

   // row: MPEG-1 L1, L2, L3, MPEG-2/2.5 L1, MPEG-2/2.5 L2 and L3
   localparam logic [8:0] KBPS_TABLE [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   localparam logic [15:0] RATE_TABLE [3][4] = '{
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd11025, 16'd12000, 16'd8000,  16'd0}
   };

   // Reciprocals scaled by 2**PROD_SHIFT: 44.1k family divides 10*M by 441,
   // 48k family divides M by 48, 32k family divides M by 32.
   localparam logic [MUL_W-1:0] DIV_MUL [4] = '{
      25'd1217395, 25'd11184811, 25'd16777216, 25'd0
   };

   typedef struct packed {
      logic             hdr_ok;
      logic [1:0]       version;
      logic [1:0]       layer;
      logic             has_crc;
      logic [8:0]       bitrate_kbps;
      logic [15:0]      sample_rate_hz;
      logic [10:0]      frame_samples;
      logic             stereo;
      logic             padding;
      logic [5:0]       side_info_offset;
      logic [NUM_W-1:0] num;
      logic [1:0]       sr_idx;
   } cls_type;

   typedef struct packed {
      logic        valid_res;
      logic [1:0]  version;
      logic [1:0]  layer;
      logic        has_crc;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [10:0] frame_samples;
      logic        stereo;
      logic        padding;
      logic [5:0]  side_info_offset;
      logic [11:0] frame_bytes;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/mahd_front.sv @@
`default_nettype none

module mahd_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [31:0]       req_header_word,
   input  wire logic              q_full,
   output logic                   push,
   output mahd_pkg::cls_type      cls
);

   logic [1:0]  vcode;
   logic [1:0]  lcode;
   logic [3:0]  br_idx;
   logic [1:0]  sr_idx;
   logic [1:0]  emph;
   logic [1:0]  mode;
   logic [1:0]  ver;
   logic [2:0]  row;
   logic        layer1;
   logic        mono;
   logic [8:0]  kbps;
   logic [15:0] kprod;
   logic [16:0] mval;
   logic [mahd_pkg::NUM_W-1:0] mext;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   assign vcode  = req_header_word[20:19];
   assign lcode  = req_header_word[18:17];
   assign br_idx = req_header_word[15:12];
   assign sr_idx = req_header_word[11:10];
   assign mode   = req_header_word[7:6];
   assign emph   = req_header_word[1:0];
   assign layer1 = (lcode == mahd_pkg::LCODE_LAYER1);
   assign mono   = (mode == mahd_pkg::MODE_MONO);

   always_comb begin
      unique case (vcode)
         mahd_pkg::VCODE_MPEG1: ver = mahd_pkg::VER_MPEG1;
         mahd_pkg::VCODE_MPEG2: ver = mahd_pkg::VER_MPEG2;
         default:               ver = mahd_pkg::VER_MPEG25;
      endcase
   end

   // keep row inside the table even for a reserved layer code
   always_comb begin
      if (ver == mahd_pkg::VER_MPEG1) begin
         row = 3'd3 - {1'b0, lcode};
      end else begin
         row = layer1 ? 3'd3 : 3'd4;
      end
   end

   assign kbps = mahd_pkg::KBPS_TABLE[row][br_idx];

   // 12 * kbps for layer 1, 144 * kbps otherwise; scaled by 2**ver to
   // fold the version into the sample rate family
   assign kprod = layer1 ? (({7'b0, kbps} << 3) + ({7'b0, kbps} << 2))
                         : (({7'b0, kbps} << 7) + ({7'b0, kbps} << 4));
   assign mval  = {1'b0, kprod} << ver;
   assign mext  = mahd_pkg::NUM_W'(mval);

   always_comb begin
      cls.hdr_ok = (req_header_word[31:21] == 11'h7FF)
                && (vcode != mahd_pkg::VCODE_RESERVED)
                && (lcode != mahd_pkg::LCODE_RESERVED)
                && (br_idx != mahd_pkg::BR_FREE)
                && (br_idx != mahd_pkg::BR_BAD)
                && (sr_idx != mahd_pkg::SR_RESERVED)
                && (emph != mahd_pkg::EMPH_RESERVED);
      cls.version        = ver;
      cls.layer          = 2'(3'd4 - {1'b0, lcode});
      cls.has_crc        = !req_header_word[16];
      cls.bitrate_kbps   = kbps;
      cls.sample_rate_hz = mahd_pkg::RATE_TABLE[ver][sr_idx];
      if (layer1) begin
         cls.frame_samples = mahd_pkg::SPF_LAYER1;
      end else if ((lcode == mahd_pkg::LCODE_LAYER2) || (ver == mahd_pkg::VER_MPEG1)) begin
         cls.frame_samples = mahd_pkg::SPF_LONG;
      end else begin
         cls.frame_samples = mahd_pkg::SPF_SHORT;
      end
      cls.stereo  = !mono;
      cls.padding = req_header_word[9];
      if (ver == mahd_pkg::VER_MPEG1) begin
         cls.side_info_offset = mono ? mahd_pkg::OFFS_M1_MONO : mahd_pkg::OFFS_M1_STEREO;
      end else begin
         cls.side_info_offset = mono ? mahd_pkg::OFFS_M2_MONO : mahd_pkg::OFFS_M2_STEREO;
      end
      // 44.1k family: divide 10*M by 441 in the back end
      if (sr_idx == mahd_pkg::SR_FAMILY_44K) begin
         cls.num = (mext << 3) + (mext << 1);
      end else begin
         cls.num = mext;
      end
      cls.sr_idx = sr_idx;
   end

endmodule

`default_nettype wire

@@ rtl/core/mahd_queue.sv @@
`default_nettype none

module mahd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mahd_pkg::cls_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   out_valid,
   output mahd_pkg::cls_type      out_data
);

   mahd_pkg::cls_type                mem_ff [mahd_pkg::QDEPTH];
   logic [mahd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mahd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mahd_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == mahd_pkg::QCNT_W'(mahd_pkg::QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mahd_back.sv @@
`default_nettype none

module mahd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire mahd_pkg::cls_type in_data,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mahd_pkg::rsp_type      rsp
);

   // stage A: reciprocal multiply
   logic                         a_valid_ff;
   mahd_pkg::cls_type            a_item_ff;
   logic [mahd_pkg::QUO_W-1:0]   a_quo_ff, a_quo_in;
   logic [mahd_pkg::PROD_W-1:0]  prod;

   // stage B: length, range check, output register
   logic                         b_valid_ff;
   mahd_pkg::rsp_type            b_rsp_ff, b_rsp_in;
   logic [mahd_pkg::LEN_W-1:0]   len_sum;
   logic [mahd_pkg::LEN_W-1:0]   len;
   logic                         len_ok;

   logic b_ready;
   logic a_ready;

   assign b_ready  = !b_valid_ff || !rsp_stall;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign prod = mahd_pkg::PROD_W'(in_data.num)
               * mahd_pkg::PROD_W'(mahd_pkg::DIV_MUL[in_data.sr_idx]);
   assign a_quo_in = prod[mahd_pkg::PROD_W-1:mahd_pkg::PROD_SHIFT];

   assign len_sum = {2'b00, a_quo_ff} + mahd_pkg::LEN_W'(a_item_ff.padding);
   assign len     = (a_item_ff.layer == mahd_pkg::LAYER_1) ? (len_sum << 2) : len_sum;
   assign len_ok  = (len != '0) && (len <= mahd_pkg::MAX_FRAME_LEN);

   always_comb begin
      b_rsp_in = '0;
      if (a_item_ff.hdr_ok && len_ok) begin
         b_rsp_in.valid_res        = 1'b1;
         b_rsp_in.version          = a_item_ff.version;
         b_rsp_in.layer            = a_item_ff.layer;
         b_rsp_in.has_crc          = a_item_ff.has_crc;
         b_rsp_in.bitrate_kbps     = a_item_ff.bitrate_kbps;
         b_rsp_in.sample_rate_hz   = a_item_ff.sample_rate_hz;
         b_rsp_in.frame_samples    = a_item_ff.frame_samples;
         b_rsp_in.stereo           = a_item_ff.stereo;
         b_rsp_in.padding          = a_item_ff.padding;
         b_rsp_in.side_info_offset = a_item_ff.side_info_offset;
         b_rsp_in.frame_bytes      = 12'(len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_item_ff <= in_data;
         a_quo_ff  <= a_quo_in;
      end
      if (b_ready && a_valid_ff) begin
         b_rsp_ff <= b_rsp_in;
      end
   end

   assign rsp_valid = b_valid_ff;
   assign rsp       = b_rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/mpeg_audio_header_decoder.sv @@
// A request beat is written into the queue, then passes the stage A and stage B
//   registers before its response is offered. Throughput: one header per cycle
//   while rsp_stall is low, set by the single reciprocal multiplier stage.
// A 4-entry queue decouples request intake from the multiply/length pipeline.
// Reset (synchronous, active high) empties the queue and drops in-flight beats.
`default_nettype none

module mpeg_audio_header_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_header_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_valid_res,
   output logic [1:0]       rsp_version,
   output logic [1:0]       rsp_layer,
   output logic             rsp_has_crc,
   output logic [8:0]       rsp_bitrate_kbps,
   output logic [15:0]      rsp_sample_rate_hz,
   output logic [10:0]      rsp_frame_samples,
   output logic             rsp_stereo,
   output logic             rsp_padding,
   output logic [5:0]       rsp_side_info_offset,
   output logic [11:0]      rsp_frame_bytes
);

   mahd_pkg::cls_type front_cls;
   mahd_pkg::cls_type q_data;
   mahd_pkg::rsp_type rsp;
   logic              push;
   logic              q_full;
   logic              q_valid;
   logic              back_ready;
   logic              pop;

   assign pop = q_valid && back_ready;

   mahd_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_header_word (req_header_word),
      .q_full          (q_full),
      .push            (push),
      .cls             (front_cls)
   );

   mahd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cls),
      .full      (q_full),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   mahd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .in_ready  (back_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_valid_res        = rsp.valid_res;
   assign rsp_version          = rsp.version;
   assign rsp_layer            = rsp.layer;
   assign rsp_has_crc          = rsp.has_crc;
   assign rsp_bitrate_kbps     = rsp.bitrate_kbps;
   assign rsp_sample_rate_hz   = rsp.sample_rate_hz;
   assign rsp_frame_samples    = rsp.frame_samples;
   assign rsp_stereo           = rsp.stereo;
   assign rsp_padding          = rsp.padding;
   assign rsp_side_info_offset = rsp.side_info_offset;
   assign rsp_frame_bytes      = rsp.frame_bytes;

   // a full queue always has a beat to offer the back end
   a_full_has_data: assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_valid)
      else $error("queue full without valid data");

   // a good header always carries a length inside the legal range
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |->
         (rsp_frame_bytes != 12'd0) && (rsp_frame_bytes <= 12'd2880))
      else $error("frame length out of range on a good header");

   // a rejected header shows all-zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_version == 2'd0) && (rsp_layer == 2'd0) && (rsp_bitrate_kbps == 9'd0)
         && (rsp_sample_rate_hz == 16'd0) && (rsp_frame_bytes == 12'd0)
         && (rsp_frame_samples == 11'd0) && (rsp_side_info_offset == 6'd0))
      else $error("rejected header with nonzero fields");

   // a good header has a real layer and version
   a_good_codes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_layer != 2'd0) && (rsp_version != 2'd3))
      else $error("good header with reserved layer or version");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
class header_scoreboard;
   mahd_pkg::rsp_type expected_q[$];
   logic [31:0]       header_q[$];
   int unsigned       errors;
   int unsigned       kbps_by_row[5][16];
   int unsigned       rate_by_ver[3][3];

   function new();
      errors = 0;
      // row: MPEG-1 L1, L2, L3, MPEG-2/2.5 L1, MPEG-2/2.5 L2 and L3
      kbps_by_row = '{
         '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
         '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
      };
      rate_by_ver = '{
         '{44100, 48000, 32000},
         '{22050, 24000, 16000},
         '{11025, 12000, 8000}
      };
   endfunction

   function mahd_pkg::rsp_type decode_header(logic [31:0] w);
      mahd_pkg::rsp_type r;
      logic [1:0]        vcode, lcode, sr, emph, ver;
      logic [3:0]        br;
      logic              mono;
      int unsigned       layer, row, kbps, rate, len, pad;
      r     = '0;
      vcode = w[20:19];
      lcode = w[18:17];
      br    = w[15:12];
      sr    = w[11:10];
      emph  = w[1:0];
      if (w[31:21] != 11'h7FF || vcode == mahd_pkg::VCODE_RESERVED ||
          lcode == mahd_pkg::LCODE_RESERVED || br == mahd_pkg::BR_FREE ||
          br == mahd_pkg::BR_BAD || sr == mahd_pkg::SR_RESERVED ||
          emph == mahd_pkg::EMPH_RESERVED)
         return r;
      layer = 4 - int'(lcode);
      if (vcode == mahd_pkg::VCODE_MPEG1)
         ver = mahd_pkg::VER_MPEG1;
      else if (vcode == mahd_pkg::VCODE_MPEG2)
         ver = mahd_pkg::VER_MPEG2;
      else
         ver = mahd_pkg::VER_MPEG25;
      if (ver == mahd_pkg::VER_MPEG1)
         row = layer - 1;
      else
         row = (layer == 1) ? 3 : 4;
      kbps = kbps_by_row[row][br];
      rate = rate_by_ver[ver][sr];
      pad  = 32'(w[9]);
      mono = (w[7:6] == mahd_pkg::MODE_MONO);
      if (layer == 1)
         len = (12 * kbps * 1000 / rate + pad) * 4;
      else
         len = 144 * kbps * 1000 / rate + pad;
      if (len == 0 || len > 2880)
         return r;
      r.valid_res      = 1'b1;
      r.version        = ver;
      r.layer          = layer[1:0];
      r.has_crc        = ~w[16];
      r.bitrate_kbps   = kbps[8:0];
      r.sample_rate_hz = rate[15:0];
      if (layer == 1)
         r.frame_samples = 11'd384;
      else if (layer == 2 || ver == mahd_pkg::VER_MPEG1)
         r.frame_samples = 11'd1152;
      else
         r.frame_samples = 11'd576;
      r.stereo  = ~mono;
      r.padding = w[9];
      if (ver == mahd_pkg::VER_MPEG1)
         r.side_info_offset = mono ? 6'd21 : 6'd36;
      else
         r.side_info_offset = mono ? 6'd13 : 6'd21;
      r.frame_bytes = len[11:0];
      return r;
   endfunction

   function void note_header(logic [31:0] w);
      expected_q.push_back(decode_header(w));
      header_q.push_back(w);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 100)
         $display("MISMATCH: %s", msg);
   endtask

   task compare(logic [31:0] w, string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report($sformatf("header %08h %s: got %0d, want %0d", w, name, got, want));
   endtask

   task check_result(mahd_pkg::rsp_type got);
      mahd_pkg::rsp_type want;
      logic [31:0]       w;
      if (expected_q.size() == 0) begin
         report("result beat with no header outstanding");
         return;
      end
      want = expected_q.pop_front();
      w    = header_q.pop_front();
      compare(w, "valid_res", 16'(got.valid_res), 16'(want.valid_res));
      compare(w, "version", 16'(got.version), 16'(want.version));
      compare(w, "layer", 16'(got.layer), 16'(want.layer));
      compare(w, "has_crc", 16'(got.has_crc), 16'(want.has_crc));
      compare(w, "bitrate_kbps", 16'(got.bitrate_kbps), 16'(want.bitrate_kbps));
      compare(w, "sample_rate_hz", got.sample_rate_hz, want.sample_rate_hz);
      compare(w, "frame_samples", 16'(got.frame_samples), 16'(want.frame_samples));
      compare(w, "stereo", 16'(got.stereo), 16'(want.stereo));
      compare(w, "padding", 16'(got.padding), 16'(want.padding));
      compare(w, "side_info_offset", 16'(got.side_info_offset),
              16'(want.side_info_offset));
      compare(w, "frame_bytes", 16'(got.frame_bytes), 16'(want.frame_bytes));
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] VCODE_MPEG25 = 2'b00;
   localparam logic [1:0] LCODE_LAYER3 = 2'b01;
   localparam logic [1:0] EMPH_NONE    = 2'b00;
   localparam logic [1:0] EMPH_50_15   = 2'b01;
   localparam logic [1:0] EMPH_CCITT   = 2'b11;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_HEADERS = 950;

   // noise bits that land on protection, padding and channel mode
   localparam logic [31:0] NO_CRC = 32'h0001_0000;
   localparam logic [31:0] PAD    = 32'h0000_0200;
   localparam logic [31:0] MONO   = 32'h0000_00C0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_header_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_valid_res;
   logic [1:0]  rsp_version;
   logic [1:0]  rsp_layer;
   logic        rsp_has_crc;
   logic [8:0]  rsp_bitrate_kbps;
   logic [15:0] rsp_sample_rate_hz;
   logic [10:0] rsp_frame_samples;
   logic        rsp_stereo;
   logic        rsp_padding;
   logic [5:0]  rsp_side_info_offset;
   logic [11:0] rsp_frame_bytes;

   header_scoreboard header_sb = new();
   int unsigned      cycle_count = 0;
   bit               quiet_tail = 1'b0;
   int               send_calm = 0;
   int               stall_left = 0;
   int               stall_calm = 0;

   mpeg_audio_header_decoder dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_header_word      (req_header_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_valid_res        (rsp_valid_res),
      .rsp_version          (rsp_version),
      .rsp_layer            (rsp_layer),
      .rsp_has_crc          (rsp_has_crc),
      .rsp_bitrate_kbps     (rsp_bitrate_kbps),
      .rsp_sample_rate_hz   (rsp_sample_rate_hz),
      .rsp_frame_samples    (rsp_frame_samples),
      .rsp_stereo           (rsp_stereo),
      .rsp_padding          (rsp_padding),
      .rsp_side_info_offset (rsp_side_info_offset),
      .rsp_frame_bytes      (rsp_frame_bytes)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response-side backpressure: bursts of stall with calm stretches in between
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         stall_left = 0;
         stall_calm = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (stall_calm > 0) begin
         stall_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_calm = $urandom_range(20, 100);
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 19);
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      mahd_pkg::rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.valid_res        = rsp_valid_res;
         got.version          = rsp_version;
         got.layer            = rsp_layer;
         got.has_crc          = rsp_has_crc;
         got.bitrate_kbps     = rsp_bitrate_kbps;
         got.sample_rate_hz   = rsp_sample_rate_hz;
         got.frame_samples    = rsp_frame_samples;
         got.stereo           = rsp_stereo;
         got.padding          = rsp_padding;
         got.side_info_offset = rsp_side_info_offset;
         got.frame_bytes      = rsp_frame_bytes;
         header_sb.check_result(got);
      end
   end

   function automatic logic [31:0] make_header(logic [1:0] vcode, logic [1:0] lcode,
                                               logic [3:0] br, logic [1:0] sr,
                                               logic [1:0] emph, logic [31:0] noise);
      return {11'h7FF, vcode, lcode, noise[16], br, sr, noise[9:2], emph};
   endfunction

   // mostly well-formed headers with random content, the rest raw noise
   function automatic logic [31:0] random_header();
      logic [31:0] noise;
      logic [31:0] w;
      logic [1:0]  vcode, lcode, sr, emph;
      logic [3:0]  br;
      noise = $urandom;
      if ($urandom_range(0, 4) == 0)
         return noise;
      vcode = 2'($urandom_range(0, 3));
      if (vcode == mahd_pkg::VCODE_RESERVED && $urandom_range(0, 3) != 0)
         vcode = ($urandom_range(0, 1) != 0) ? mahd_pkg::VCODE_MPEG1 : VCODE_MPEG25;
      lcode = 2'($urandom_range(0, 3));
      if (lcode == mahd_pkg::LCODE_RESERVED && $urandom_range(0, 3) != 0)
         lcode = 2'($urandom_range(1, 3));
      br = 4'($urandom_range(0, 15));
      if ((br == mahd_pkg::BR_FREE || br == mahd_pkg::BR_BAD) && $urandom_range(0, 3) != 0)
         br = 4'($urandom_range(1, 14));
      sr = 2'($urandom_range(0, 3));
      if (sr == mahd_pkg::SR_RESERVED && $urandom_range(0, 3) != 0)
         sr = 2'($urandom_range(0, 2));
      emph = 2'($urandom_range(0, 3));
      if (emph == mahd_pkg::EMPH_RESERVED && $urandom_range(0, 3) != 0)
         emph = ($urandom_range(0, 1) != 0) ? EMPH_CCITT : EMPH_50_15;
      w = make_header(vcode, lcode, br, sr, emph, noise);
      // now and then a broken sync word
      if ($urandom_range(0, 31) == 0)
         w[31:21] = noise[31:21];
      return w;
   endfunction

   task send_header(logic [31:0] w);
      int gap;
      if (!quiet_tail) begin
         if (send_calm > 0) begin
            send_calm--;
         end else if ($urandom_range(0, 19) == 0) begin
            send_calm = $urandom_range(10, 60);
         end else if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_header_word <= w;
      // hold the beat until the decoder takes it
      do @(posedge clock); while (req_stall);
      header_sb.note_header(w);
   endtask

   initial begin
      logic [31:0] mp3;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      mp3 = make_header(mahd_pkg::VCODE_MPEG1, LCODE_LAYER3, 4'd9, 2'd0, EMPH_NONE, NO_CRC);
      send_header(32'h0000_0000);
      send_header(32'hFFFF_FFFF);
      send_header(mp3);
      send_header(mp3 & 32'h7FFF_FFFF);
      send_header(mp3 & ~32'h0020_0000);
      send_header(make_header(mahd_pkg::VCODE_RESERVED, LCODE_LAYER3, 4'd9, 2'd0,
                              EMPH_NONE, '0));
      send_header(make_header(mahd_pkg::VCODE_MPEG1, mahd_pkg::LCODE_RESERVED, 4'd9, 2'd0,
                              EMPH_NONE, '0));
      send_header(make_header(mahd_pkg::VCODE_MPEG1, mahd_pkg::LCODE_LAYER2,
                              mahd_pkg::BR_FREE, 2'd1, EMPH_NONE, '0));
      send_header(make_header(mahd_pkg::VCODE_MPEG2, mahd_pkg::LCODE_LAYER1,
                              mahd_pkg::BR_BAD, 2'd1, EMPH_NONE, '0));
      send_header(make_header(mahd_pkg::VCODE_MPEG1, LCODE_LAYER3, 4'd5,
                              mahd_pkg::SR_RESERVED, EMPH_NONE, '0));
      send_header(make_header(mahd_pkg::VCODE_MPEG1, LCODE_LAYER3, 4'd5, 2'd1,
                              mahd_pkg::EMPH_RESERVED, '0));
      // each version and layer; longest and shortest frames
      send_header(make_header(mahd_pkg::VCODE_MPEG1, mahd_pkg::LCODE_LAYER1, 4'd14, 2'd2,
                              EMPH_50_15, PAD | MONO));
      send_header(make_header(mahd_pkg::VCODE_MPEG1, mahd_pkg::LCODE_LAYER2, 4'd14, 2'd2,
                              EMPH_CCITT, PAD | NO_CRC));
      send_header(make_header(mahd_pkg::VCODE_MPEG1, LCODE_LAYER3, 4'd1, 2'd1,
                              EMPH_NONE, MONO));
      send_header(make_header(mahd_pkg::VCODE_MPEG2, mahd_pkg::LCODE_LAYER1, 4'd14, 2'd0,
                              EMPH_NONE, NO_CRC));
      send_header(make_header(mahd_pkg::VCODE_MPEG2, mahd_pkg::LCODE_LAYER2, 4'd5, 2'd1,
                              EMPH_50_15, MONO));
      send_header(make_header(mahd_pkg::VCODE_MPEG2, LCODE_LAYER3, 4'd14, 2'd2,
                              EMPH_NONE, PAD));
      send_header(make_header(VCODE_MPEG25, mahd_pkg::LCODE_LAYER1, 4'd14, 2'd2,
                              EMPH_CCITT, PAD | NO_CRC));
      send_header(make_header(VCODE_MPEG25, mahd_pkg::LCODE_LAYER2, 4'd14, 2'd2,
                              EMPH_NONE, '0));
      send_header(make_header(VCODE_MPEG25, mahd_pkg::LCODE_LAYER2, 4'd14, 2'd2,
                              EMPH_NONE, PAD));
      send_header(make_header(VCODE_MPEG25, LCODE_LAYER3, 4'd7, 2'd0,
                              EMPH_CCITT, MONO | NO_CRC));
      send_header(make_header(VCODE_MPEG25, LCODE_LAYER3, 4'd14, 2'd2,
                              EMPH_NONE, PAD | MONO));

      for (int i = 0; i < RANDOM_HEADERS; i++) begin
         if (i >= RANDOM_HEADERS - 100)
            quiet_tail = 1'b1;
         send_header(random_header());
      end
      req_valid <= 1'b0;

      while (header_sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (header_sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
